// ===== rtl/gps_delta_varint_encoder_core_defines.svh =====
// Assertion macros used by the encoder serializer.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef GPS_DELTA_VARINT_ENCODER_CORE_DEFINES_SVH
`define GPS_DELTA_VARINT_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define GDVE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gdve assertion failed");

// Next-cycle implication, disabled while reset is held
`define GDVE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gdve assertion failed");

`endif

// ===== rtl/gdve_pkg.sv =====
// Types and constants for the GPS delta/zigzag/varint encoder.
// No dependencies.
package gdve_pkg;

    localparam int unsigned NUM_LANES  = 4;
    localparam int unsigned LANE_BYTES = 5;

    localparam logic [7:0] FULL_HEADER = 8'hFF;
    localparam logic [2:0] FULL_WORD_LEN = 3'd4;

    // bytes of one field, as emitted, and how many of them are used
    typedef struct packed {
        logic [LANE_BYTES-1:0][7:0] bytes;
        logic [2:0]                 len;
    } t_lane_res;

    // one encoded block waiting to be sent; lane 3 is the timestamp
    typedef struct packed {
        logic                           full;
        t_lane_res [NUM_LANES-1:0]      lane;
    } t_block;

endpackage

// ===== rtl/gps_delta_varint_encoder_core.sv =====
// Top level of the GPS track point encoder: state, four field lanes, block
// register and byte serializer. Depends on gdve_pkg, gdve_lane, gdve_serializer.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | mode, timestamp, lat, lon, alt
//  out     | output    | o_out_valid / i_out_stall  | out_byte, last_byte, full_block
//  cfg     | input     | i_cfg_wr_en                | i_cfg_wr_data (block interval)
//
// A block has 17 bytes when full and 1 to 21 bytes as a delta block; the serializer
// emits one byte a cycle while the output is not stalled.
// A point's first byte passes the block register, the serializer's current block and
// the output register; the next point is taken into the block register while the
// current block drains. A clear word (mode 1) emits nothing.
// Reset is synchronous, active low; output stalls back up through the block register.
module gps_delta_varint_encoder_core
    import gdve_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic        [31:0] i_timestamp,
    input  logic signed [31:0] i_latitude,
    input  logic signed [31:0] i_longitude,
    input  logic signed [31:0] i_altitude,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic        [7:0]  o_out_byte,
    output logic               o_last_byte,
    output logic               o_full_block,
    input  logic               i_cfg_wr_en,
    input  logic        [15:0] i_cfg_wr_data
);

    logic [15:0] r_interval;
    logic [31:0] r_prev_ts;
    logic [31:0] r_prev_lat;
    logic [31:0] r_prev_lon;
    logic [31:0] r_prev_alt;
    logic [15:0] r_deltas;
    logic        r_first;
    logic        r_desc_valid;
    t_block      r_desc;

    logic [15:0] interval_m1;
    logic        is_full;
    logic        in_take;
    logic        desc_take;
    t_block      n_desc;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= 16'd1;
        end else if (i_cfg_wr_en) begin
            r_interval <= i_cfg_wr_data;
        end
    end

    // full block decision; an interval of zero acts as one
    assign interval_m1 = (r_interval == 16'd0) ? 16'd0 : r_interval - 16'd1;
    assign is_full     = r_first || (interval_m1 == 16'd0) || (r_deltas >= interval_m1);

    // field lanes
    gdve_lane u_lane_ts  (.i_full(is_full), .i_value(i_timestamp),
                          .i_prev(r_prev_ts),  .o_res(n_desc.lane[3]));
    gdve_lane u_lane_lat (.i_full(is_full), .i_value(i_latitude),
                          .i_prev(r_prev_lat), .o_res(n_desc.lane[2]));
    gdve_lane u_lane_lon (.i_full(is_full), .i_value(i_longitude),
                          .i_prev(r_prev_lon), .o_res(n_desc.lane[1]));
    gdve_lane u_lane_alt (.i_full(is_full), .i_value(i_altitude),
                          .i_prev(r_prev_alt), .o_res(n_desc.lane[0]));
    assign n_desc.full = is_full;

    assign o_in_stall = r_desc_valid && !desc_take;
    assign in_take    = i_in_valid && !o_in_stall;

    // encoder state: update on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ts  <= 32'd0;
            r_prev_lat <= 32'd0;
            r_prev_lon <= 32'd0;
            r_prev_alt <= 32'd0;
            r_deltas   <= 16'd0;
            r_first    <= 1'b1;
        end else if (in_take) begin
            if (i_mode) begin
                r_prev_ts  <= 32'd0;
                r_prev_lat <= 32'd0;
                r_prev_lon <= 32'd0;
                r_prev_alt <= 32'd0;
                r_deltas   <= 16'd0;
                r_first    <= 1'b1;
            end else begin
                r_prev_ts  <= i_timestamp;
                r_prev_lat <= i_latitude;
                r_prev_lon <= i_longitude;
                r_prev_alt <= i_altitude;
                r_deltas   <= is_full ? 16'd0 : r_deltas + 16'd1;
                r_first    <= 1'b0;
            end
        end
    end

    // block register between lanes and serializer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc_valid <= 1'b0;
        end else begin
            if (desc_take) begin
                r_desc_valid <= 1'b0;
            end
            if (in_take && !i_mode) begin
                r_desc_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && !i_mode) begin
            r_desc <= n_desc;
        end
    end

    gdve_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (r_desc_valid),
        .i_desc       (r_desc),
        .o_desc_take  (desc_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte),
        .o_full_block (o_full_block)
    );

endmodule

// ===== rtl/gdve_lane.sv =====
// One field lane: full-block word bytes or wrapped delta as zigzag varint.
// Depends on gdve_pkg.
module gdve_lane
    import gdve_pkg::*;
(
    input  logic        i_full,
    input  logic [31:0] i_value,
    input  logic [31:0] i_prev,
    output t_lane_res   o_res
);

    logic [31:0] delta;
    logic [31:0] zz;
    logic [2:0]  n_groups;

    // wrapped delta and zigzag
    assign delta = i_value - i_prev;
    assign zz    = {delta[30:0], 1'b0} ^ {32{delta[31]}};

    // count 7-bit groups up to the highest nonzero one
    assign n_groups = 3'd1 + {2'b0, |zz[31:7]} + {2'b0, |zz[31:14]}
                    + {2'b0, |zz[31:21]} + {2'b0, |zz[31:28]};

    // select byte layout for the block kind
    always_comb begin
        if (i_full) begin
            for (int j = 0; j < 4; j++) begin
                o_res.bytes[j] = i_value[8*j +: 8];
            end
            o_res.bytes[4] = 8'h00;
            o_res.len      = FULL_WORD_LEN;
        end else begin
            for (int j = 0; j < 4; j++) begin
                o_res.bytes[j] = {(3'(j + 1) < n_groups), zz[7*j +: 7]};
            end
            o_res.bytes[4] = {4'b0, zz[31:28]};
            o_res.len      = (delta == 32'd0) ? 3'd0 : n_groups;
        end
    end

endmodule

// ===== rtl/gdve_serializer.sv =====
// Merge stage: walks header and four lanes of a block into a registered output,
// one byte a cycle unless stalled. Depends on gdve_pkg and the defines header.
`include "gps_delta_varint_encoder_core_defines.svh"
module gdve_serializer
    import gdve_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_desc_valid,
    input  t_block     i_desc,
    output logic       o_desc_take,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte,
    output logic       o_full_block
);

    logic       r_busy;
    logic       r_in_hdr;
    logic [1:0] r_lane;
    logic [2:0] r_idx;
    t_block     r_cur;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       r_ofull;

    logic [NUM_LANES-1:0] nonempty;
    logic [7:0] cur_byte;
    logic [2:0] cur_len;
    logic       lane_end;
    logic       emit;
    logic       cur_last;
    logic       nxt_found;
    logic [1:0] nxt_lane;
    logic [2:0] hi_lane;

    // which lanes still carry bytes
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            nonempty[i] = (r_cur.lane[i].len != 3'd0);
        end
    end

    assign cur_len  = r_cur.lane[r_lane].len;
    assign lane_end = (r_idx == cur_len - 3'd1);

    // highest nonempty lane below the search start; timestamp lane goes first
    assign hi_lane = r_in_hdr ? 3'(NUM_LANES) : {1'b0, r_lane};
    always_comb begin
        nxt_found = 1'b0;
        nxt_lane  = 2'd0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (nonempty[i] && (3'(i) < hi_lane)) begin
                nxt_found = 1'b1;
                nxt_lane  = 2'(i);
            end
        end
    end

    // current byte and end of block
    always_comb begin
        if (r_in_hdr) begin
            cur_byte = r_cur.full ? FULL_HEADER : {4'b0, nonempty};
            cur_last = !nxt_found;
        end else begin
            cur_byte = r_cur.lane[r_lane].bytes[r_idx];
            cur_last = lane_end && !nxt_found;
        end
    end

    assign emit        = r_busy && (!r_ovalid || !i_out_stall);
    assign o_desc_take = i_desc_valid && (!r_busy || (emit && cur_last));

    // advance through the block, load the next one when done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_desc_take) begin
            r_busy   <= 1'b1;
            r_in_hdr <= 1'b1;
            r_lane   <= 2'd0;
            r_idx    <= 3'd0;
            r_cur    <= i_desc;
        end else if (emit) begin
            if (cur_last) begin
                r_busy <= 1'b0;
            end else if (!r_in_hdr && !lane_end) begin
                r_idx <= r_idx + 3'd1;
            end else begin
                r_in_hdr <= 1'b0;
                r_lane   <= nxt_lane;
                r_idx    <= 3'd0;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
            r_obyte  <= cur_byte;
            r_olast  <= cur_last;
            r_ofull  <= r_cur.full;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_last_byte  = r_olast;
    assign o_full_block = r_ofull;

    `GDVE_ASSERT_NOW(a_hdr_idx_zero, r_busy && r_in_hdr, r_idx == 3'd0)
    `GDVE_ASSERT_NOW(a_idx_in_lane, r_busy && !r_in_hdr, r_idx < cur_len)
    `GDVE_ASSERT_NEXT(a_load_starts_hdr, o_desc_take, r_busy && r_in_hdr)
    `GDVE_ASSERT_NOW(a_full_lane_len, r_busy && r_cur.full && !r_in_hdr,
                     cur_len == FULL_WORD_LEN)

endmodule

// ===== tb/gps_delta_varint_encoder_core_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for gps_delta_varint_encoder_core and the mode codes shared with the bench top.
// Predicts the byte stream of every accepted point word and compares it with the output channel.
// Depends on gdve_pkg.
package gdve_tb_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

endpackage

module gps_delta_varint_encoder_core_checker
    import gdve_pkg::*;
    import gdve_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_mode,
    input  logic [31:0] i_timestamp,
    input  logic [31:0] i_latitude,
    input  logic [31:0] i_longitude,
    input  logic [31:0] i_altitude,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_last_byte,
    input  logic        i_full_block,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_bytes_pending
);

    localparam logic [7:0]  VARINT_CONT  = 8'h80;
    localparam logic [31:0] VARINT_LIMIT = 32'h80;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       full;
    } t_enc_byte;

    t_enc_byte   enc_bytes_q[$];
    logic [15:0] interval_reg;
    // previous point: timestamp, latitude, longitude, altitude
    logic [31:0] prev_field [4];
    logic [15:0] deltas_since_full;
    logic        first_point;
    int          fail_count = 0;

    // return the track to its start; the interval register is kept
    task automatic clear_track();
        for (int f = 0; f < 4; f++)
            prev_field[f] = 32'd0;
        deltas_since_full = 16'd0;
        first_point = 1'b1;
    endtask

    // predict the block of one point and queue its bytes
    task automatic encode_point(input logic [31:0] ts, la, lo, al);
        logic [31:0] now_field [4];
        logic [31:0] delta;
        logic [31:0] zz;
        logic [15:0] period;
        logic [7:0]  hdr;
        logic [7:0]  blk [$];
        logic        is_full;
        now_field[0] = ts;
        now_field[1] = la;
        now_field[2] = lo;
        now_field[3] = al;
        // a zero interval behaves as one
        period = (interval_reg == 16'd0) ? 16'd1 : interval_reg;
        is_full = first_point || period == 16'd1 || deltas_since_full >= period - 16'd1;
        if (is_full) begin
            blk.push_back(FULL_HEADER);
            for (int f = 0; f < 4; f++)
                for (int b = 0; b < 4; b++)
                    blk.push_back(now_field[f][8*b +: 8]);
            deltas_since_full = 16'd0;
            first_point = 1'b0;
        end else begin
            // header bit 3 flags the timestamp, bit 0 the altitude
            hdr = 8'd0;
            for (int f = 0; f < 4; f++)
                hdr[3 - f] = (now_field[f] != prev_field[f]);
            blk.push_back(hdr);
            // emit each nonzero wrapped delta as a zigzag varint, low group first
            for (int f = 0; f < 4; f++) begin
                delta = now_field[f] - prev_field[f];
                if (delta != 32'd0) begin
                    zz = (delta << 1) ^ {32{delta[31]}};
                    while (zz >= VARINT_LIMIT) begin
                        blk.push_back(VARINT_CONT | zz[7:0]);
                        zz = zz >> 7;
                    end
                    blk.push_back(zz[7:0]);
                end
            end
            deltas_since_full = deltas_since_full + 16'd1;
        end
        prev_field = now_field;
        for (int k = 0; k < blk.size(); k++)
            enc_bytes_q.push_back('{value: blk[k], last: (k == blk.size() - 1), full: is_full});
    endtask

    always @(posedge i_clk) begin
        t_enc_byte want;
        if (!i_rst_n) begin
            enc_bytes_q.delete();
            interval_reg = 16'd1;
            clear_track();
        end else begin
            // compare each accepted output word with the oldest predicted byte
            if (i_out_valid && !i_out_stall) begin
                if (enc_bytes_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no byte, got byte %02h last %b full %b",
                             $time, i_out_byte, i_last_byte, i_full_block);
                end else begin
                    want = enc_bytes_q.pop_front();
                    if (i_out_byte !== want.value) begin
                        fail_count++;
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.value, i_out_byte);
                    end
                    if (i_last_byte !== want.last) begin
                        fail_count++;
                        $display("%0t: last_byte expected %b, got %b",
                                 $time, want.last, i_last_byte);
                    end
                    if (i_full_block !== want.full) begin
                        fail_count++;
                        $display("%0t: full_block expected %b, got %b",
                                 $time, want.full, i_full_block);
                    end
                end
            end
            // predict the accepted input word with the interval before this edge
            if (i_in_valid && !i_in_stall) begin
                if (i_mode == MODE_CLEAR)
                    clear_track();
                else
                    encode_point(i_timestamp, i_latitude, i_longitude, i_altitude);
            end
            // track the interval register
            if (i_cfg_wr_en)
                interval_reg = i_cfg_wr_data;
        end
        o_fail_count    <= fail_count;
        o_bytes_pending <= enc_bytes_q.size();
    end

endmodule

// ===== tb/gps_delta_varint_encoder_core_tb.sv =====
`timescale 1ns / 100ps
// Bench top for gps_delta_varint_encoder_core: clock, reset, point stimulus, pacing, verdict.
// Depends on gdve_tb_pkg and gps_delta_varint_encoder_core_checker.
module gps_delta_varint_encoder_core_tb;
    import gdve_tb_pkg::*;

    localparam int          RESET_CYCLES     = 12;
    localparam int          SETTLE_CYCLES    = 8;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          PHASE_WORDS      = 35;
    localparam int          NUM_PHASES       = 8;
    localparam int          DRAIN_LIMIT      = 100000;
    localparam logic [15:0] INTERVAL_MAX     = 16'hFFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_mode;
    logic [31:0] i_timestamp;
    logic [31:0] i_latitude;
    logic [31:0] i_longitude;
    logic [31:0] i_altitude;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;
    logic        o_full_block;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    int          fail_count;
    int          bytes_pending;
    bit          long_hold_go = 1'b0;
    bit          gaps_on = 1'b1;
    int          burst_left = 0;
    logic [31:0] cur_ts, cur_lat, cur_lon, cur_alt;
    logic [15:0] phase_interval [NUM_PHASES] =
        '{16'd2, 16'd3, 16'd1, 16'd5, 16'd0, INTERVAL_MAX, 16'd16, 16'd4};

    gps_delta_varint_encoder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_timestamp   (i_timestamp),
        .i_latitude    (i_latitude),
        .i_longitude   (i_longitude),
        .i_altitude    (i_altitude),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte),
        .o_full_block  (o_full_block),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    gps_delta_varint_encoder_core_checker scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_timestamp     (i_timestamp),
        .i_latitude      (i_latitude),
        .i_longitude     (i_longitude),
        .i_altitude      (i_altitude),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_byte      (o_out_byte),
        .i_last_byte     (o_last_byte),
        .i_full_block    (o_full_block),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_fail_count    (fail_count),
        .o_bytes_pending (bytes_pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // give up after a generous fixed time
    initial begin
        #4000000;
        $display("gps_delta_varint_encoder_core: mismatch");
        $finish;
    end

    // receiver: stretches of random stall density, one long hold-off on request
    initial begin : rx_pace
        int hold_left;
        int stretch_left;
        int pct;
        bit hold_done;
        hold_left = 0;
        stretch_left = 0;
        pct = 0;
        hold_done = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (long_hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 20;
                        2: pct = 50;
                        default: pct = 85;
                    endcase
                end
                stretch_left--;
                i_out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // offer one word and hold it until accepted
    task automatic send_word(input logic mode, input logic [31:0] ts, la, lo, al);
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_timestamp <= ts;
        i_latitude  <= la;
        i_longitude <= lo;
        i_altitude  <= al;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // end a burst now and then with a random gap
    task automatic pace_sender();
        int gap;
        if (burst_left > 0 || !gaps_on) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_point(input logic [31:0] ts, la, lo, al);
        cur_ts  = ts;
        cur_lat = la;
        cur_lon = lo;
        cur_alt = al;
        send_word(MODE_ENCODE, ts, la, lo, al);
        pace_sender();
    endtask

    // a clear word carries random payload that the block must ignore
    task automatic send_clear();
        send_word(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
        pace_sender();
    endtask

    // pause the sender until every predicted byte has come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (bytes_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [31:0] rand_delta();
        case ($urandom_range(0, 7))
            0, 1:    return 32'd0;
            2:       return $urandom_range(0, 127) - 32'd64;
            3:       return $urandom_range(0, 16383) - 32'd8192;
            4:       return $urandom_range(0, 2097151) - 32'd1048576;
            5:       return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] ts_step();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            5:       return $urandom;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    // mostly a plausible next point of the track, some clears and wild points
    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            send_clear();
        else if (pick < 12)
            send_point($urandom, $urandom, $urandom, $urandom);
        else
            send_point(cur_ts + ts_step(), cur_lat + rand_delta(),
                       cur_lon + rand_delta(), cur_alt + rand_delta());
    endtask

    initial begin : stimulus
        int waited;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_ENCODE;
        i_timestamp   = 32'd0;
        i_latitude    = 32'd0;
        i_longitude   = 32'd0;
        i_altitude    = 32'd0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 16'd0;
        cur_ts  = 32'd0;
        cur_lat = 32'd0;
        cur_lon = 32'd0;
        cur_alt = 32'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // full blocks at the field extremes, interval at its reset value
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_point(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

        // zero interval: every point stays a full block
        wait_idle();
        write_interval(16'd0);
        send_point(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_point(cur_ts, cur_lat, cur_lon, cur_alt);

        // delta blocks: unchanged point, short and longest varints
        wait_idle();
        write_interval(INTERVAL_MAX);
        send_clear();
        send_point(32'd1000, 32'd0, 32'd0, 32'd0);
        send_point(cur_ts, cur_lat, cur_lon, cur_alt);
        send_point(cur_ts + 32'd1, cur_lat, cur_lon, cur_alt);
        send_point(cur_ts, cur_lat - 32'd1, cur_lon + 32'd64, cur_alt + 32'd63);
        send_point(cur_ts + 32'h8000_0000, cur_lat + 32'h8000_0000,
                   cur_lon + 32'h8000_0000, cur_alt + 32'h8000_0000);
        send_point(cur_ts + 32'h7FFF_FFFF, cur_lat + 32'h7FFF_FFFF,
                   cur_lon + 32'h7FFF_FFFF, cur_alt + 32'h7FFF_FFFF);
        send_point(cur_ts - 32'd64, cur_lat + 32'd8192, cur_lon - 32'd8193, cur_alt);

        // clear restarts with a full block, then build up a run of deltas
        send_clear();
        send_point(32'd5000, 32'd4_500_000, -32'd7_300_000, 32'd1200);
        repeat (4) send_point(cur_ts + 32'd5, cur_lat + 32'd17, cur_lon - 32'd3, cur_alt);

        // shrink the interval below the delta count: next point is full
        wait_idle();
        write_interval(16'd3);
        repeat (3) send_point(cur_ts + 32'd1, cur_lat + 32'd1, cur_lon, cur_alt - 32'd1);
        send_clear();
        repeat (3) send_point(cur_ts + 32'd2, cur_lat, cur_lon + 32'd9, cur_alt);

        // random phases, one interval setting each
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            if (p == NUM_PHASES - 1)
                write_interval(16'($urandom_range(2, 20)));
            else
                write_interval(phase_interval[p]);
            // in one phase, keep offering back to back while the receiver holds off
            gaps_on = (p != 1);
            long_hold_go = long_hold_go || (p == 1);
            repeat (PHASE_WORDS) random_word();
        end
        gaps_on = 1'b1;

        // drain what is left, then watch for stray bytes
        i_in_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (bytes_pending != 0 && waited < DRAIN_LIMIT);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && bytes_pending == 0)
            $display("gps_delta_varint_encoder_core: match");
        else
            $display("gps_delta_varint_encoder_core: mismatch");
        $finish;
    end

endmodule
